// ----- design/osr_pkg.sv -----
// Shared widths, constants, command struct and rounding helper of the obstacle speed regulator.
`default_nettype none

package osr_pkg;

	// Field widths.
	localparam int DIST_W     = 11;
	localparam int PITCH_W    = 17;
	localparam int SEC_W      = 10;
	localparam int USER_W     = 14;
	localparam int SPEED_W    = 16;
	localparam int ERR_W      = 20;
	localparam int Q_W        = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Datapath widths.
	localparam int MAG_W  = 7;
	localparam int QUO_W  = 12;
	localparam int MUL_W  = 21;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 34;
	localparam int RS_W   = 48;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SECURITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USER     = 2'd1;

	localparam logic [SEC_W-1:0]         SEC_RESET  = 10'd100;
	localparam logic signed [USER_W-1:0] USER_RESET = 14'sd410;

	// Distance ratio: |diff| * 4096 / 100, done as a reciprocal multiply.
	localparam logic [DIST_W-1:0]       RATIO_LIMIT = 11'd100;
	localparam logic [18:0]             RATIO_BIAS  = 19'd50;
	localparam logic signed [MUL_W-1:0] RECIP_100   = 21'sd671089;
	localparam int                      RECIP_SHIFT = 26;

	// Q0.16 coefficients and Q.12 unity.
	localparam logic signed [MUL_W-1:0] COEF_PITCH = 21'sd2818;
	localparam logic signed [MUL_W-1:0] COEF_PREV  = 21'sd13631;
	localparam logic signed [MUL_W-1:0] COEF_NEW   = 21'sd3212;
	localparam logic signed [Q_W-1:0]   ONE_Q12    = 14'sd4096;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

	// Multiplier operand selection.
	localparam logic [2:0] MUL_NONE  = 3'd0;
	localparam logic [2:0] MUL_RECIP = 3'd1;
	localparam logic [2:0] MUL_PITCH = 3'd2;
	localparam logic [2:0] MUL_BASE  = 3'd3;
	localparam logic [2:0] MUL_PREV  = 3'd4;
	localparam logic [2:0] MUL_NEW   = 3'd5;

	typedef logic signed [DIST_W-1:0]     dist_t;
	typedef logic signed [PITCH_W-1:0]    pitch_t;
	typedef logic signed [SPEED_W-1:0]    speed_t;
	typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_sample;
		logic [2:0] mul_sel;
		logic       cap_ratio;
		logic       cap_est;
		logic       cap_base;
		logic       cap_acc;
		logic       upd_err;
		logic       sub_acc;
		logic       load_out;
	} osr_cmd_t;

	// Arithmetic right shift that rounds to nearest, halves away from zero.
	function automatic logic signed [RS_W-1:0] round_shift(input logic signed [RS_W-1:0] v,
			input int unsigned sh);
		logic signed [RS_W-1:0] half;
		half = '0;
		half[sh-1] = 1'b1;
		if (v[RS_W-1]) begin
			half = half - RS_W'(1);
		end
		return (v + half) >>> sh;
	endfunction

endpackage

`default_nettype wire

// ----- design/osr_if.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none

interface osr_sample_if import osr_pkg::*; ();
	logic   valid;
	logic   ready;
	dist_t  front_distance;
	pitch_t pitch_angle;

	modport source(output valid, front_distance, pitch_angle, input ready);
	modport sink(input valid, front_distance, pitch_angle, output ready);
endinterface

interface osr_result_if import osr_pkg::*; ();
	logic   valid;
	logic   ready;
	speed_t speed_factor;

	modport source(output valid, speed_factor, input ready);
	modport sink(input valid, speed_factor, output ready);
endinterface

interface osr_cfg_if import osr_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/osr_ctrl.sv -----
// Sequencing state machine and result handshake of the obstacle speed regulator.
`default_nettype none

module osr_ctrl import osr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sample_valid,
	output logic          sample_ready,
	output logic          result_valid,
	input  wire logic     result_ready,
	output osr_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RECIP = 3'd1;
	localparam logic [2:0] ST_PITCH = 3'd2;
	localparam logic [2:0] ST_BASE  = 3'd3;
	localparam logic [2:0] ST_PREV  = 3'd4;
	localparam logic [2:0] ST_NEW   = 3'd5;
	localparam logic [2:0] ST_SUM   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		cmd          = '0;
		cmd.mul_sel  = MUL_NONE;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_RECIP;
				end
			end
			ST_RECIP: begin
				cmd.mul_sel = MUL_RECIP;
				state_d     = ST_PITCH;
			end
			ST_PITCH: begin
				cmd.cap_ratio = 1'b1;
				cmd.mul_sel   = MUL_PITCH;
				state_d       = ST_BASE;
			end
			ST_BASE: begin
				cmd.cap_est = 1'b1;
				cmd.mul_sel = MUL_BASE;
				state_d     = ST_PREV;
			end
			ST_PREV: begin
				cmd.cap_base = 1'b1;
				cmd.mul_sel  = MUL_PREV;
				state_d      = ST_NEW;
			end
			ST_NEW: begin
				cmd.cap_acc = 1'b1;
				cmd.upd_err = 1'b1;
				cmd.mul_sel = MUL_NEW;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sub_acc = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// The output register is reloaded only once its last result is gone.
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> state_q == ST_RECIP)
		else $error("accepted sample did not start the sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || result_ready)
		else $error("pending result overwritten");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && !cmd.load_out |=> state_q == ST_OUT)
		else $error("output step left without loading the result");

endmodule

`default_nettype wire

// ----- design/osr_dp.sv -----
// Datapath: configuration registers, regulator state and one shared multiplier.
`default_nettype none

module osr_dp import osr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire osr_cmd_t  cmd,
	input  wire dist_t     front_distance,
	input  wire pitch_t    pitch_angle,
	input  wire logic      cfg_we,
	input  wire cfg_idx_t  cfg_index,
	input  wire cfg_data_t cfg_data,
	output speed_t         speed_factor
);

	logic [SEC_W-1:0]         sec_q;
	logic signed [USER_W-1:0] user_q;
	dist_t                    stored_q;
	logic signed [ERR_W-1:0]  prev_err_q;

	pitch_t                   pitch_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic                     sat_q;
	logic signed [Q_W-1:0]    ratio_q;
	logic signed [PITCH_W-1:0] est_q;
	logic signed [Q_W-1:0]    base_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	speed_t                   out_q;

	dist_t                    stored_d;
	logic signed [DIST_W:0]   diff;
	logic [DIST_W:0]          mag;
	logic [18:0]              recip_x;
	logic signed [MUL_W-1:0]  a_op;
	logic signed [MUL_W-1:0]  b_op;
	logic signed [ERR_W-1:0]  err_d;
	logic [Q_W-1:0]           ratio_mag;
	logic signed [RS_W-1:0]   est_r;
	logic signed [RS_W-1:0]   base_r;
	logic signed [RS_W-1:0]   out_r;

	// A valid reading is stored; a missing one turns a positive distance into -1.
	always_comb begin
		if (!front_distance[DIST_W-1]) begin
			stored_d = front_distance;
		end else if (stored_q > 0) begin
			stored_d = -DIST_W'(1);
		end else begin
			stored_d = stored_q;
		end
		diff = (DIST_W + 1)'(stored_d) - $signed({2'b00, sec_q});
		mag  = diff[DIST_W] ? $unsigned(-diff) : $unsigned(diff);
	end

	assign recip_x = {mag_q, 12'd0} + RATIO_BIAS;
	assign err_d   = ERR_W'(base_q) - ERR_W'(est_q);

	always_comb begin
		case (cmd.mul_sel)
			MUL_RECIP: begin
				a_op = $signed(MUL_W'(recip_x));
				b_op = RECIP_100;
			end
			MUL_PITCH: begin
				a_op = MUL_W'(pitch_q);
				b_op = COEF_PITCH;
			end
			MUL_BASE: begin
				a_op = MUL_W'(ratio_q);
				b_op = MUL_W'(user_q);
			end
			MUL_PREV: begin
				a_op = MUL_W'(prev_err_q);
				b_op = COEF_PREV;
			end
			MUL_NEW: begin
				a_op = MUL_W'(err_d);
				b_op = COEF_NEW;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign ratio_mag = sat_q ? ONE_Q12 : Q_W'(prod_q[RECIP_SHIFT +: QUO_W]);
	assign est_r     = round_shift(RS_W'(prod_q), 12);
	assign base_r    = round_shift(RS_W'(prod_q), 12);
	assign out_r     = round_shift(RS_W'(acc_q), 16);

	// Configuration and regulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q      <= SEC_RESET;
			user_q     <= USER_RESET;
			stored_q   <= '0;
			prev_err_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SECURITY: sec_q  <= cfg_data[SEC_W-1:0];
					REG_USER:     user_q <= cfg_data[USER_W-1:0];
					default:      ;
				endcase
			end
			if (cmd.load_sample) begin
				stored_q <= stored_d;
			end
			if (cmd.upd_err) begin
				prev_err_q <= err_d;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
		if (cmd.load_sample) begin
			pitch_q <= pitch_angle;
			neg_q   <= diff[DIST_W];
			sat_q   <= mag[DIST_W-1:0] >= RATIO_LIMIT;
			mag_q   <= mag[MAG_W-1:0];
		end
		if (cmd.cap_ratio) begin
			ratio_q <= neg_q ? -$signed(ratio_mag) : $signed(ratio_mag);
		end
		if (cmd.cap_est) begin
			est_q <= est_r[PITCH_W-1:0];
		end
		if (cmd.cap_base) begin
			if (base_r > RS_W'(ONE_Q12)) begin
				base_q <= ONE_Q12;
			end else if (base_r < -RS_W'(ONE_Q12)) begin
				base_q <= -ONE_Q12;
			end else begin
				base_q <= base_r[Q_W-1:0];
			end
		end
		if (cmd.cap_acc) begin
			acc_q <= prod_q[ACC_W-1:0] + {{(ACC_W - Q_W - 16){base_q[Q_W-1]}}, base_q, 16'd0};
		end else if (cmd.sub_acc) begin
			acc_q <= acc_q - prod_q[ACC_W-1:0];
		end
		if (cmd.load_out) begin
			if (out_r > RS_W'(SPEED_MAX)) begin
				out_q <= SPEED_MAX;
			end else if (out_r < RS_W'(SPEED_MIN)) begin
				out_q <= SPEED_MIN;
			end else begin
				out_q <= out_r[SPEED_W-1:0];
			end
		end
	end

	assign speed_factor = out_q;

endmodule

`default_nettype wire

// ----- design/obstacle_speed_regulator_core.sv -----
// Top level of the obstacle speed regulator: channels, controller and datapath.
//
// Each sample transfer carries a front distance in cm (negative when the sensor has no
// reading) and a pitch angle in Q8.8 degrees, and produces exactly one speed factor
// transfer in Q3.12, saturated to 16 bits. The block keeps the last valid distance and
// the previous control error across samples; both clear on reset, which also sets the
// security distance (100 cm) and the user command (410, about 0.1), which the user must
// write through the configuration channel at indexes 0 and 1 only while no sample is in
// flight; the block itself does not enforce this. Other indexes are accepted and ignored,
// and the configuration channel is always ready. One sample occupies the block from
// its transfer until its result is loaded. The shared 21x21 multiplier computes in turn the
// distance ratio (a reciprocal multiply standing in for the division by 100), the pitch
// estimate, the base command, and the two error terms, each product registered before it
// is rounded and used. The next sample transfer is taken as soon as the result sits in
// the output register, so a waiting result does not hold back the input; a result that
// is still not taken when the following one is ready stalls the sequence in its last step.
`default_nettype none

module obstacle_speed_regulator_core import osr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	osr_sample_if.sink  sample,
	osr_result_if.source result,
	osr_cfg_if.sink     cfg
);

	osr_cmd_t cmd;
	logic     cfg_we;

	// Configuration writes complete in the cycle they are offered.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid & cfg.ready;

	osr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	osr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.front_distance (sample.front_distance),
		.pitch_angle    (sample.pitch_angle),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.speed_factor   (result.speed_factor)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench of the obstacle speed regulator core.
`timescale 1ns / 100ps

module tb_top;
	import osr_pkg::*;

	// Reset values of the two registers and the fixed-point constants of the control law.
	localparam int SEC_AT_RESET  = 100;
	localparam int USER_AT_RESET = 410;
	localparam int UNITY         = 4096;
	localparam int K_PITCH       = 2818;
	localparam int K_PREV        = 13631;
	localparam int K_NEW         = 3212;

	// Register indexes that the block accepts and ignores.
	localparam cfg_idx_t IDX_SPARE_2 = 2'd2;
	localparam cfg_idx_t IDX_SPARE_3 = 2'd3;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 105;
	localparam int DRAIN_CYCLES   = 8;

	logic clk = 1'b0;
	logic arst_n;

	osr_sample_if smp_ch();
	osr_result_if res_ch();
	osr_cfg_if    cfg_ch();

	obstacle_speed_regulator_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the regulator state and of its two registers.
	dist_t                      held_dist = '0;
	logic signed [ERR_W-1:0]    prev_err  = '0;
	logic [SEC_W-1:0]           sec_dist  = SEC_W'(SEC_AT_RESET);
	logic signed [USER_W-1:0]   user_cmd  = USER_W'(USER_AT_RESET);

	// Speed factors still owed by the block, oldest first.
	speed_t speed_queue[$];

	int  error_count = 0;
	int  idle_cycles = 0;
	// When set, neither side inserts gaps, so each transfer goes as soon as the block allows.
	bit  no_idle = 1'b0;

	// One line of the directed plan: either a register write or a sample, and for a
	// few samples a speed factor that is obvious without working through the math.
	typedef struct {
		bit        is_cfg;
		cfg_idx_t  idx;
		cfg_data_t data;
		dist_t     dist_cm;
		pitch_t    pitch;
		bit        typed;
		speed_t    speed;
	} plan_row_t;

	plan_row_t plan[$];

	// Shift right with rounding to nearest; a half rounds away from zero.
	function automatic longint round_away(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Works out the speed factor of one sample and advances the held distance and the
	// previous error, exactly as the block does for each accepted sample transfer.
	function automatic speed_t predict_speed(dist_t dist_cm, pitch_t pitch);
		longint diff, mag, ratio, base, est, err, acc, outv;
		// A valid reading is kept. A missing one only marks a positive distance as lost;
		// a held zero or a held -1 stays as it is.
		if (dist_cm >= 0) begin
			held_dist = dist_cm;
		end else if (held_dist > 0) begin
			held_dist = -1;
		end
		diff = longint'(held_dist) - longint'(sec_dist);
		mag  = (diff < 0) ? -diff : diff;
		// Distance ratio in Q.12, one full unit at 100 cm or more from the security distance.
		ratio = (mag >= 100) ? UNITY : (mag * UNITY + 50) / 100;
		if (diff < 0) begin
			ratio = -ratio;
		end
		base = clamp_to(round_away(ratio * longint'(user_cmd), 12), -UNITY, UNITY);
		// Q8.8 pitch times a Q0.16 coefficient, brought to Q.12.
		est  = round_away(longint'(pitch) * K_PITCH, 12);
		err  = base - est;
		acc  = longint'(prev_err) * K_PREV - err * K_NEW + base * 65536;
		outv = clamp_to(round_away(acc, 16), -32768, 32767);
		prev_err = err[ERR_W-1:0];
		return speed_t'(outv);
	endfunction

	function automatic void apply_cfg(cfg_idx_t idx, cfg_data_t data);
		case (idx)
			REG_SECURITY: sec_dist = data[SEC_W-1:0];
			REG_USER:     user_cmd = data[USER_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void add_sample(dist_t dist_cm, pitch_t pitch);
		plan.push_back('{1'b0, '0, '0, dist_cm, pitch, 1'b0, '0});
	endfunction

	function automatic void add_typed(dist_t dist_cm, pitch_t pitch, speed_t speed);
		plan.push_back('{1'b0, '0, '0, dist_cm, pitch, 1'b1, speed});
	endfunction

	function automatic void add_write(cfg_idx_t idx, cfg_data_t data);
		plan.push_back('{1'b1, idx, data, '0, '0, 1'b0, '0});
	endfunction

	task automatic flag_mismatch(string what);
		error_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Offers one sample after a random gap and records what it must produce once the
	// transfer happens. The valid stays high afterwards so that a following sample with
	// no gap is offered without a break in the valid.
	task automatic send_sample(dist_t dist_cm, pitch_t pitch, bit typed, speed_t typed_speed);
		int     gap;
		speed_t want;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid          <= 1'b1;
		smp_ch.front_distance <= dist_cm;
		smp_ch.pitch_angle    <= pitch;
		do @(posedge clk); while (!smp_ch.ready);
		want = predict_speed(dist_cm, pitch);
		speed_queue.push_back(typed ? typed_speed : want);
	endtask

	// A register write; with hold set the valid stays up for a write that follows.
	task automatic write_reg(cfg_idx_t idx, cfg_data_t data, bit hold);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_cfg(idx, data);
		if (!hold) begin
			cfg_ch.valid <= 1'b0;
		end
	endtask

	// Stops offering samples and waits until every owed speed factor has been taken,
	// then lets the block settle before registers change.
	task automatic drain();
		smp_ch.valid <= 1'b0;
		while (speed_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers in a random order, sometimes with an ignored index mixed in.
	task automatic program_regs(int sec, int user);
		cfg_data_t sec_data, user_data;
		bit        user_first, with_spare;
		sec_data   = cfg_data_t'($urandom);
		user_data  = cfg_data_t'($urandom);
		sec_data[SEC_W-1:0]   = sec[SEC_W-1:0];
		user_data[USER_W-1:0] = user[USER_W-1:0];
		user_first = $urandom_range(0, 1);
		with_spare = $urandom_range(0, 1);
		if (with_spare) begin
			write_reg($urandom_range(0, 1) ? IDX_SPARE_2 : IDX_SPARE_3,
				cfg_data_t'($urandom), 1'b1);
		end
		if (user_first) begin
			write_reg(REG_USER, user_data, 1'b1);
			write_reg(REG_SECURITY, sec_data, 1'b0);
		end else begin
			write_reg(REG_SECURITY, sec_data, 1'b1);
			write_reg(REG_USER, user_data, 1'b0);
		end
	endtask

	// Distances mostly fall near the security distance so that the ratio is often
	// between its limits; the rest are missing readings or anything at all.
	function automatic dist_t pick_dist();
		int kind, v;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			return dist_t'(-1 - int'($urandom_range(0, 1023)));
		end
		if (kind == 2) begin
			return dist_t'($urandom);
		end
		v = int'(sec_dist) + int'($urandom_range(0, 240)) - 120;
		return dist_t'(clamp_to(v, 0, 1023));
	endfunction

	function automatic pitch_t pick_pitch();
		if ($urandom_range(0, 9) < 2) begin
			return pitch_t'($urandom);
		end
		return pitch_t'(int'($urandom_range(0, 8000)) - 4000);
	endfunction

	// The result side draws a stall before it is willing to take each speed factor.
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Every speed factor transfer is held against the oldest one still owed.
	always @(posedge clk) begin
		speed_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (speed_queue.size() == 0) begin
				flag_mismatch($sformatf("speed factor %0d with none owed",
					res_ch.speed_factor));
			end else begin
				want = speed_queue.pop_front();
				if (res_ch.speed_factor !== want) begin
					flag_mismatch($sformatf("speed factor %0d, expected %0d",
						res_ch.speed_factor, want));
				end
			end
		end
	end

	// Watchdog: a long stretch with no transfer on any channel means the block hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int sec, user;
		bit hold;
		arst_n                <= 1'b0;
		smp_ch.valid          <= 1'b0;
		smp_ch.front_distance <= '0;
		smp_ch.pitch_angle    <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= '0;
		cfg_ch.data           <= '0;

		// Directed plan. Under the reset settings a sample exactly at the security
		// distance with a level pitch gives zero. Then the handling of a missing reading
		// against a positive, a -1 and a zero held distance, the distance and pitch
		// extremes, and pitches whose estimate lands exactly on a half.
		add_typed(100, 0, 0);
		add_sample(-1, 0);
		add_sample(-1024, 1024);
		add_sample(0, -1024);
		add_sample(-7, 0);
		add_sample(1023, 46080);
		add_sample(150, -46080);
		add_sample(199, 65535);
		add_sample(101, -65536);
		add_sample(50, 1);
		add_sample(1, -1);
		// Security distance zero and a full positive user command: the ratio runs from
		// zero to its limit right at 100 cm.
		add_write(REG_SECURITY, 16'd0);
		add_write(REG_USER, 16'd4096);
		add_sample(0, 0);
		add_sample(99, 0);
		add_sample(100, 512);
		add_sample(-1, 0);
		// Upper data bits are dropped: this sets the largest security distance and a
		// full negative user command.
		add_write(REG_SECURITY, 16'hFFFF);
		add_write(REG_USER, 16'hF000);
		add_sample(1023, 0);
		add_sample(923, 0);
		add_sample(924, -300);
		add_sample(0, 0);
		// User commands beyond one unit are taken as written; the clamp after the
		// product bounds the base command. Writes to unused indexes change nothing.
		add_write(REG_USER, 16'h1FFF);
		add_write(IDX_SPARE_2, 16'hFFFF);
		add_sample(1000, 0);
		add_write(REG_USER, 16'h2000);
		add_write(IDX_SPARE_3, 16'h0000);
		add_sample(1000, 200);
		// A zero user command leaves only the previous error, so two level samples in a
		// row end at zero.
		add_write(REG_USER, 16'd0);
		add_sample(500, 0);
		add_typed(500, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				// Registers only change with nothing in flight.
				if (i == 0 || !plan[i-1].is_cfg) begin
					drain();
				end
				hold = (i + 1 < plan.size()) && plan[i+1].is_cfg;
				write_reg(plan[i].idx, plan[i].data, hold);
			end else begin
				send_sample(plan[i].dist_cm, plan[i].pitch, plan[i].typed, plan[i].speed);
			end
		end

		// Random phases, each under its own register settings. The first keeps the reset
		// settings, the next four take register extremes; two run with no gaps on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin sec = SEC_AT_RESET; user = USER_AT_RESET; end
				1: begin sec = 0;            user = 4096;          end
				2: begin sec = 1023;         user = -4096;         end
				3: begin sec = $urandom_range(0, 1023); user = 8191;  end
				4: begin sec = $urandom_range(0, 1023); user = -8192; end
				default: begin
					sec  = $urandom_range(0, 1023);
					user = int'($urandom_range(0, 16383)) - 8192;
				end
			endcase
			program_regs(sec, user);
			no_idle = (ph == 2 || ph == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_sample(pick_dist(), pick_pitch(), 1'b0, '0);
			end
		end

		no_idle = 1'b0;
		drain();
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
